[src/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PAFM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pafm assertion failed");

// expression must never be true at a clock edge outside reset
`define PAFM_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pafm forbidden condition seen");

`endif

[src/pafm_pkg.sv]
`timescale 1ns / 1ps

package pafm_pkg;

  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int OPC_W    = 1;
  localparam int REL_IN_W = 2;
  localparam int PAGE_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int STAT_W   = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_PAGE = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    op_e                 opcode;
    logic [REL_IN_W-1:0] relation;
    logic [PAGE_W-1:0]   page_number;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [PAGE_W-1:0]  granted_page;
    logic [COUNT_W-1:0] page_count;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_ACCEPT,
    DP_REJECT,
    DP_GROW,
    DP_FULL,
    DP_SCAN_START,
    DP_SCAN_NEXT,
    DP_SCAN_HIT,
    DP_FREE_RD,
    DP_MARK,
    DP_TRIM_FIRST,
    DP_TRIM_NEXT,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic rel_ok;
    logic is_free;
    logic n_zero;
    logic n_full;
    logic page_absent;
    logic page_top;
    logic scan_hit;
    logic scan_last;
    logic tail_hit_first;
    logic tail_hit_next;
    logic chk_zero;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

[src/pafm_ctrl.sv]
`timescale 1ns / 1ps

module pafm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pafm_pkg::dp_status_t status_i,
  output pafm_pkg::cmd_t       cmd_o
);
  import pafm_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_TRIM  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!status_i.rel_ok) begin
          cmd_o.op = DP_REJECT;
          state_d  = S_DONE;
        end else if (!status_i.is_free) begin
          if (status_i.n_zero) begin
            cmd_o.op = DP_GROW;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = DP_SCAN_START;
            state_d  = S_SCAN;
          end
        end else if (status_i.page_absent) begin
          cmd_o.op = DP_REJECT;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = DP_FREE_RD;
          state_d  = S_FREE;
        end
      end
      S_SCAN: begin
        if (status_i.scan_hit) begin
          cmd_o.op = DP_SCAN_HIT;
          state_d  = S_DONE;
        end else if (status_i.scan_last) begin
          cmd_o.op = status_i.n_full ? DP_FULL : DP_GROW;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = DP_SCAN_NEXT;
        end
      end
      S_FREE: begin
        if (!status_i.page_top) begin
          cmd_o.op = DP_MARK;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = DP_TRIM_FIRST;
          if (status_i.tail_hit_first || status_i.chk_zero) begin
            state_d = S_DONE;
          end else begin
            state_d = S_TRIM;
          end
        end
      end
      S_TRIM: begin
        cmd_o.op = DP_TRIM_NEXT;
        if (status_i.tail_hit_next || status_i.chk_zero) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

[src/pafm_dp.sv]
`timescale 1ns / 1ps

module pafm_dp #(
  parameter int MAX_PAGES = 1024,
  parameter int RELATIONS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pafm_pkg::cmd_t       cmd_i,
  output pafm_pkg::dp_status_t status_o,
  input  pafm_pkg::in_item_t   in_item_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output pafm_pkg::out_item_t  out_item_o
);
  import pafm_pkg::*;

  localparam int WPR    = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int DEPTH  = RELATIONS * WPR;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIDX_W = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int REL_W  = (RELATIONS > 1) ? $clog2(RELATIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int PG_W   = $clog2(MAX_PAGES);
  localparam int CW     = (CNT_W > PAGE_W + 1) ? CNT_W : PAGE_W + 1;

  function automatic logic [BIT_W-1:0] low_index(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] high_index(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // ones in every bit position below k, k may equal the word width
  function automatic logic [WORD_W-1:0] below(input logic [BIT_W:0] k);
    return (WORD_W'(1) << k) - WORD_W'(1);
  endfunction

  logic [WORD_W-1:0] bitmap_mem [DEPTH];
  logic [CNT_W-1:0]  count_mem  [RELATIONS];

  in_item_t          item_q;
  logic [CNT_W-1:0]  cnt_rd_q;
  logic [CNT_W-1:0]  n_q;
  logic [WIDX_W-1:0] chk_q;
  status_e           status_q;
  logic [PG_W-1:0]   granted_q;
  logic [WORD_W-1:0] mem_rd_q;
  logic [AW-1:0]     clr_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic [REL_W-1:0]  rel_idx;
  logic              rel_ok;
  logic [AW-1:0]     base;
  logic [WIDX_W-1:0] page_word;
  logic [BIT_W-1:0]  page_bit;
  logic [WIDX_W-1:0] last_word;
  logic [BIT_W-1:0]  low_idx;
  logic [BIT_W-1:0]  high_idx;
  logic [WORD_W-1:0] used_first;
  logic [WORD_W-1:0] used_next;
  logic [WORD_W-1:0] used;
  logic [WORD_W-1:0] keep;
  logic              out_free;

  logic              rd_en;
  logic [WIDX_W-1:0] rd_word;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              cnt_wr_en;
  logic [REL_W-1:0]  cnt_wr_idx;
  logic [CNT_W-1:0]  cnt_wr_data;

  assign rel_idx    = REL_W'(item_q.relation);
  assign rel_ok     = int'(item_q.relation) < RELATIONS;
  assign base       = AW'(rel_idx) * AW'(WPR);
  assign page_word  = WIDX_W'(item_q.page_number >> BIT_W);
  assign page_bit   = item_q.page_number[BIT_W-1:0];
  assign last_word  = WIDX_W'((cnt_rd_q - CNT_W'(1)) >> BIT_W);
  assign low_idx    = low_index(mem_rd_q);
  assign used_first = ~mem_rd_q & below({1'b0, page_bit});
  assign used_next  = ~mem_rd_q;
  assign used       = (cmd_i.op == DP_TRIM_FIRST) ? used_first : used_next;
  assign high_idx   = high_index(used);
  assign keep       = below({1'b0, high_idx} + (BIT_W + 1)'(1));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign status_o.rel_ok         = rel_ok;
  assign status_o.is_free        = (item_q.opcode == OP_FREE);
  assign status_o.n_zero         = (cnt_rd_q == '0);
  assign status_o.n_full         = (cnt_rd_q == CNT_W'(MAX_PAGES));
  assign status_o.page_absent    = CW'(item_q.page_number) >= CW'(cnt_rd_q);
  assign status_o.page_top       = (CW'(item_q.page_number) + CW'(1)) == CW'(cnt_rd_q);
  assign status_o.scan_hit       = |mem_rd_q;
  assign status_o.scan_last      = (chk_q == last_word);
  assign status_o.tail_hit_first = |used_first;
  assign status_o.tail_hit_next  = |used_next;
  assign status_o.chk_zero       = (chk_q == '0);
  assign status_o.clr_last       = (clr_q == AW'(DEPTH - 1));
  assign status_o.out_free       = out_free;

  always_comb begin
    rd_en       = 1'b0;
    rd_word     = '0;
    wr_en       = 1'b0;
    wr_addr     = base + AW'(chk_q);
    wr_data     = '0;
    cnt_wr_en   = 1'b0;
    cnt_wr_idx  = rel_idx;
    cnt_wr_data = n_q;
    case (cmd_i.op)
      DP_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_q;
        cnt_wr_en   = int'(clr_q) < RELATIONS;
        cnt_wr_idx  = REL_W'(clr_q);
        cnt_wr_data = '0;
      end
      DP_SCAN_START: begin
        rd_en = 1'b1;
      end
      DP_SCAN_NEXT: begin
        rd_en   = 1'b1;
        rd_word = chk_q + WIDX_W'(1);
      end
      DP_SCAN_HIT: begin
        wr_en   = 1'b1;
        wr_data = mem_rd_q & (mem_rd_q - WORD_W'(1));
      end
      DP_FREE_RD: begin
        rd_en   = 1'b1;
        rd_word = page_word;
      end
      DP_MARK: begin
        wr_en   = 1'b1;
        wr_data = mem_rd_q | (WORD_W'(1) << page_bit);
      end
      DP_TRIM_FIRST, DP_TRIM_NEXT: begin
        wr_en   = 1'b1;
        wr_data = (|used) ? (mem_rd_q & keep) : '0;
        rd_en   = !(|used) && (chk_q != '0);
        rd_word = chk_q - WIDX_W'(1);
      end
      DP_FINISH: begin
        cnt_wr_en = rel_ok;
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = base + AW'(rd_word);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bitmap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q <= bitmap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_wr_en) begin
      count_mem[cnt_wr_idx] <= cnt_wr_data;
    end
    if (cmd_i.op == DP_ACCEPT) begin
      cnt_rd_q <= count_mem[REL_W'(in_item_i.relation)];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_ACCEPT: begin
        item_q <= in_item_i;
      end
      DP_REJECT: begin
        status_q  <= ST_NO_PAGE;
        granted_q <= '0;
        n_q       <= rel_ok ? cnt_rd_q : '0;
      end
      DP_GROW: begin
        status_q  <= ST_OK;
        granted_q <= PG_W'(cnt_rd_q);
        n_q       <= cnt_rd_q + CNT_W'(1);
      end
      DP_FULL: begin
        status_q  <= ST_FULL;
        granted_q <= '0;
        n_q       <= cnt_rd_q;
      end
      DP_SCAN_START: begin
        chk_q <= '0;
        n_q   <= cnt_rd_q;
      end
      DP_SCAN_NEXT: begin
        chk_q <= chk_q + WIDX_W'(1);
      end
      DP_SCAN_HIT: begin
        status_q  <= ST_OK;
        granted_q <= PG_W'({chk_q, low_idx});
      end
      DP_FREE_RD: begin
        chk_q <= page_word;
        n_q   <= cnt_rd_q;
      end
      DP_MARK: begin
        status_q  <= ST_OK;
        granted_q <= '0;
      end
      DP_TRIM_FIRST, DP_TRIM_NEXT: begin
        status_q  <= ST_OK;
        granted_q <= '0;
        if (|used) begin
          n_q <= CNT_W'({chk_q, high_idx}) + CNT_W'(1);
        end else begin
          n_q <= '0;
          if (chk_q != '0) begin
            chk_q <= chk_q - WIDX_W'(1);
          end
        end
      end
      DP_FINISH: begin
        out_item_q.status       <= status_q;
        out_item_q.granted_page <= PAGE_W'(granted_q);
        out_item_q.page_count   <= COUNT_W'(n_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.op == DP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[src/page_allocator_free_map.sv]
`timescale 1ns / 1ps

// Lowest-first page allocator: per relation a page count and a free bitmap held in
// 64-page words in one RAM. Allocate walks the relation's bitmap one word per cycle
// from page 0 and hands out the lowest free page, or grows the relation by one page
// (status full at MAX_PAGES pages); free marks a page free or, when it was the
// highest page, drops it and trims trailing free pages, walking the bitmap downward
// one word per cycle. One item at a time: an allocate walks up to ceil(count/64)
// of the 64-page words, and a free trims downward from the freed page's word; the
// bitmap RAM's single read port sets the walk rate. The result sits in an output
// register, so a new item is taken while it waits. After reset a clearing pass over
// all RELATIONS * ceil(MAX_PAGES/64) bitmap words zeroes the bitmap and counts, with
// in_stall_o held high.
module page_allocator_free_map #(
  parameter int MAX_PAGES = 1024,
  parameter int RELATIONS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pafm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pafm_pkg::out_item_t out_item_o
);
  import pafm_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  pafm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  pafm_dp #(
    .MAX_PAGES (MAX_PAGES),
    .RELATIONS (RELATIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

[src/pafm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pafm_checker #(
  parameter int MAX_PAGES = 1024
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pafm_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pafm_pkg::out_item_t out_item_o
);
  import pafm_pkg::*;

  `PAFM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
  `PAFM_ASSERT(a_clear_after_reset, clk_i, rst_ni, $past(!rst_ni) |-> in_stall_o)
  `PAFM_ASSERT_NEVER(a_err_no_grant, clk_i, rst_ni, out_valid_o && (out_item_o.status != ST_OK) && (out_item_o.granted_page != '0))
  `PAFM_ASSERT(a_full_count, clk_i, rst_ni, out_valid_o && (out_item_o.status == ST_FULL) |-> out_item_o.page_count == COUNT_W'(MAX_PAGES))
  `PAFM_ASSERT(a_grant_in_range, clk_i, rst_ni, out_valid_o && (out_item_o.status == ST_OK) && (out_item_o.granted_page != '0) && (MAX_PAGES <= (1 << PAGE_W)) |-> COUNT_W'(out_item_o.granted_page) < out_item_o.page_count)

endmodule

bind page_allocator_free_map pafm_checker #(.MAX_PAGES(MAX_PAGES)) u_pafm_checker (.*);
